>>> hw/rtl/pfa_pkg.sv
package pfa_pkg;

   typedef logic [1:0] opcode_type;
   typedef logic [1:0] status_type;

   // request opcodes
   localparam opcode_type OP_ALLOC = 2'd0;
   localparam opcode_type OP_RUN   = 2'd1;
   localparam opcode_type OP_FREE  = 2'd2;
   localparam opcode_type OP_INIT  = 2'd3;

   // response status codes
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_OOM    = 2'd1;
   localparam status_type ST_DOUBLE = 2'd2;
   localparam status_type ST_FULL   = 2'd3;

   // register file
   localparam int CSR_IDX_BITS = 2;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;
   localparam csr_idx_type CSR_START_FRAME = 2'd0;
   localparam csr_idx_type CSR_END_FRAME   = 2'd1;

   // end of RAM after reset, as a frame number
   localparam int          PAGE_SHIFT      = 12;
   localparam logic [63:0] RAM_END_ADDR    = 64'h0000_0000_5000_0000;
   localparam logic [63:0] END_FRAME_RESET = RAM_END_ADDR >> PAGE_SHIFT;

endpackage

>>> hw/rtl/pfa_req_if.sv
interface pfa_req_if #(
   parameter int FRAME_BITS = 20
);
   logic                     valid;
   logic                     ready;
   pfa_pkg::opcode_type      opcode;
   logic [FRAME_BITS-1:0]    frame_in;
   logic [FRAME_BITS:0]      run_length;

   modport source (output valid, output opcode, output frame_in, output run_length,
                   input ready);
   modport sink   (input valid, input opcode, input frame_in, input run_length,
                   output ready);
endinterface

>>> hw/rtl/pfa_rsp_if.sv
interface pfa_rsp_if #(
   parameter int FRAME_BITS = 20
);
   logic                     valid;
   logic                     ready;
   logic [FRAME_BITS-1:0]    frame_out;
   pfa_pkg::status_type      status;

   modport source (output valid, output frame_out, output status, input ready);
   modport sink   (input valid, input frame_out, input status, output ready);
endinterface

>>> hw/rtl/pfa_csr_if.sv
interface pfa_csr_if #(
   parameter int FRAME_BITS = 20
);
   logic                     valid;
   logic                     ready;
   pfa_pkg::csr_idx_type     index;
   logic [FRAME_BITS:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/page_frame_allocator.sv
// Page frame allocator, working in frame numbers (byte address / 4096).
// req_bus carries one request item: opcode (alloc one, alloc run, free, init),
// frame_in for free and run_length for a run allocation. rsp_bus returns
// exactly one item per request: frame_out and a status code (ok, out of
// memory, double free, free stack full). csr_bus writes start_frame (index 0)
// and end_frame (index 1); it is always ready, and the user must write it only
// while idle: the block does not enforce this. Alloc from the frontier, run,
// init and free into an empty stack pass from the request straight into the
// output register; a pop of a freed frame reads the stack and answers from
// S_POP; a free scans the stacked frames in S_SCAN through the single read
// port of the stack to find a double free. One item is in work at a time.
// Reset clears the frontier, the stack count and the registers (end_frame
// goes to the end of RAM); stack contents stay as they are and need no pass.
// The response sits in an output register; while the receiver stalls it is
// held, and a new request is taken once that register is free or draining.
module page_frame_allocator #(
   parameter int FREE_DEPTH = 1024,
   parameter int FRAME_BITS = 20
) (
   input  logic   clock,
   input  logic   reset,
   pfa_req_if.sink   req_bus,
   pfa_rsp_if.source rsp_bus,
   pfa_csr_if.sink   csr_bus
);
   import pfa_pkg::*;

   localparam int ADDR_W = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(FREE_DEPTH + 1);

   // frames are handed out only below min(end_frame, 2^FRAME_BITS)
   localparam logic [63:0] WIDE_MASK  = (64'd1 << (FRAME_BITS + 1)) - 64'd1;
   localparam logic [63:0] END_MASKED = END_FRAME_RESET & WIDE_MASK;
   localparam logic [63:0] LIMIT64    = 64'd1 << FRAME_BITS;
   localparam logic [63:0] END_LIM64  = (END_MASKED > LIMIT64) ? LIMIT64 : END_MASKED;
   localparam logic [FRAME_BITS:0] END_LIM_RESET = END_LIM64[FRAME_BITS:0];
   localparam logic [FRAME_BITS:0] FRAME_LIMIT   = {1'b1, {FRAME_BITS{1'b0}}};

   logic [FRAME_BITS:0]   start_ff;
   logic [FRAME_BITS:0]   end_lim_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FRAME_BITS-1:0] rsp_frame_ff;
   status_type            rsp_status_ff;

   logic                  out_free;
   logic                  res_valid;
   logic [FRAME_BITS-1:0] res_frame;
   status_type            res_status;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [FRAME_BITS-1:0] mem_wdata;
   logic                  mem_re;
   logic [ADDR_W-1:0]     mem_raddr;
   logic [FRAME_BITS-1:0] mem_rdata;

   // register writes: keep end_frame already clipped to the frame range
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff   <= '0;
         end_lim_ff <= END_LIM_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_START_FRAME: start_ff <= csr_bus.data;
            CSR_END_FRAME: begin
               end_lim_ff <= (csr_bus.data > FRAME_LIMIT) ? FRAME_LIMIT : csr_bus.data;
            end
            default: begin
               // unknown register: drop the write
            end
         endcase
      end
   end

   // output register: free when empty or being taken this cycle
   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_valid) begin
         rsp_frame_ff  <= res_frame;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.frame_out = rsp_frame_ff;
   assign rsp_bus.status    = rsp_status_ff;

   pfa_ctrl #(
      .FREE_DEPTH (FREE_DEPTH),
      .FRAME_BITS (FRAME_BITS),
      .ADDR_W     (ADDR_W),
      .CNT_W      (CNT_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .out_free    (out_free),
      .start_frame (start_ff),
      .end_lim     (end_lim_ff),
      .res_valid   (res_valid),
      .res_frame   (res_frame),
      .res_status  (res_status),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re      (mem_re),
      .mem_raddr   (mem_raddr),
      .mem_rdata   (mem_rdata)
   );

   pfa_stack_mem #(
      .DEPTH  (FREE_DEPTH),
      .WIDTH  (FRAME_BITS),
      .ADDR_W (ADDR_W)
   ) u_stack (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !res_valid)
      else $error("response overwritten while stalled");

   a_end_clipped: assert property (@(posedge clock) disable iff (reset)
      end_lim_ff <= FRAME_LIMIT)
      else $error("end limit beyond frame range");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |=> rsp_valid_ff && $stable(rsp_frame_ff))
      else $error("stalled response changed");
`endif

endmodule

>>> hw/rtl/pfa_stack_mem.sv
module pfa_stack_mem #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 20,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] stack_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         stack_mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= stack_mem[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

>>> hw/rtl/pfa_ctrl.sv
module pfa_ctrl #(
   parameter int FREE_DEPTH = 1024,
   parameter int FRAME_BITS = 20,
   parameter int ADDR_W     = 10,
   parameter int CNT_W      = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   pfa_req_if.sink               req_bus,
   input  logic                  out_free,
   input  logic [FRAME_BITS:0]   start_frame,
   input  logic [FRAME_BITS:0]   end_lim,
   output logic                  res_valid,
   output logic [FRAME_BITS-1:0] res_frame,
   output pfa_pkg::status_type   res_status,
   output logic                  mem_we,
   output logic [ADDR_W-1:0]     mem_waddr,
   output logic [FRAME_BITS-1:0] mem_wdata,
   output logic                  mem_re,
   output logic [ADDR_W-1:0]     mem_raddr,
   input  logic [FRAME_BITS-1:0] mem_rdata
);
   import pfa_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FREE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   logic [1:0]            st_ff, st_in;
   logic [FRAME_BITS:0]   frontier_ff, frontier_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;

   logic                  accept;
   logic [CNT_W-1:0]      cnt_m1;
   logic [FRAME_BITS+1:0] run_sum;

   assign req_bus.ready = (st_ff == S_IDLE) && out_free;
   assign accept        = req_bus.valid && req_bus.ready;
   assign cnt_m1        = count_ff - CNT_ONE;
   assign run_sum       = {1'b0, frontier_ff} + {1'b0, req_bus.run_length};

   always_comb begin
      st_in       = st_ff;
      frontier_in = frontier_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      frame_in    = frame_ff;
      res_valid   = 1'b0;
      res_frame   = '0;
      res_status  = ST_OK;
      mem_we      = 1'b0;
      mem_waddr   = count_ff[ADDR_W-1:0];
      mem_wdata   = frame_ff;
      mem_re      = 1'b0;
      mem_raddr   = scan_ff[ADDR_W-1:0];

      case (st_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_bus.opcode)
                  OP_ALLOC: begin
                     if (count_ff != '0) begin
                        // pop the most recently freed frame
                        mem_re    = 1'b1;
                        mem_raddr = cnt_m1[ADDR_W-1:0];
                        count_in  = cnt_m1;
                        st_in     = S_POP;
                     end else if (frontier_ff < end_lim) begin
                        res_valid   = 1'b1;
                        res_frame   = frontier_ff[FRAME_BITS-1:0];
                        frontier_in = frontier_ff + {{FRAME_BITS{1'b0}}, 1'b1};
                     end else begin
                        res_valid  = 1'b1;
                        res_status = ST_OOM;
                     end
                  end
                  OP_RUN: begin
                     res_valid = 1'b1;
                     if (run_sum > {1'b0, end_lim}) begin
                        res_status = ST_OOM;
                     end else begin
                        res_frame   = frontier_ff[FRAME_BITS] ? '0
                                                               : frontier_ff[FRAME_BITS-1:0];
                        frontier_in = run_sum[FRAME_BITS:0];
                     end
                  end
                  OP_FREE: begin
                     frame_in = req_bus.frame_in;
                     if (count_ff != '0) begin
                        // start the duplicate scan at the stack bottom
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        scan_in   = CNT_ONE;
                        st_in     = S_SCAN;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = '0;
                        mem_wdata = req_bus.frame_in;
                        count_in  = CNT_ONE;
                        res_valid = 1'b1;
                     end
                  end
                  default: begin
                     frontier_in = start_frame;
                     count_in    = '0;
                     res_valid   = 1'b1;
                  end
               endcase
            end
         end
         S_POP: begin
            res_valid = 1'b1;
            res_frame = mem_rdata;
            st_in     = S_IDLE;
         end
         S_SCAN: begin
            if (mem_rdata == frame_ff) begin
               res_valid  = 1'b1;
               res_status = ST_DOUBLE;
               st_in      = S_IDLE;
            end else if (scan_ff == count_ff) begin
               res_valid = 1'b1;
               st_in     = S_IDLE;
               if (count_ff == DEPTH_C) begin
                  res_status = ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CNT_ONE;
               end
            end else begin
               mem_re  = 1'b1;
               scan_in = scan_ff + CNT_ONE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= S_IDLE;
         frontier_ff <= '0;
         count_ff    <= '0;
      end else begin
         st_ff       <= st_in;
         frontier_ff <= frontier_in;
         count_ff    <= count_in;
      end
      scan_ff  <= scan_in;
      frame_ff <= frame_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("free stack count beyond depth");

   a_double_from_scan: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_status == ST_DOUBLE) |-> st_ff == S_SCAN)
      else $error("double free reported outside a scan");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("stack read and write in one cycle");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_POP) |-> count_ff == $past(count_ff) - CNT_ONE)
      else $error("pop did not shrink the stack");
`endif

endmodule

>>> tb/sv/pfa_alloc_checker.sv
`timescale 1ns / 100ps

module pfa_alloc_checker #(
   parameter int FREE_DEPTH = 1024,
   parameter int FRAME_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  pfa_pkg::opcode_type   req_opcode,
   input  logic [FRAME_BITS-1:0] req_frame_in,
   input  logic [FRAME_BITS:0]   req_run_length,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [FRAME_BITS-1:0] rsp_frame_out,
   input  pfa_pkg::status_type   rsp_status,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  pfa_pkg::csr_idx_type  csr_index,
   input  logic [FRAME_BITS:0]   csr_data,
   output int                    mismatch_count,
   output int                    pending_results,
   output int                    checked_count,
   output int                    oom_count,
   output int                    double_count,
   output int                    full_count
);
   import pfa_pkg::*;

   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [FRAME_BITS:0]   wide_type;
   typedef struct packed {
      frame_type  frame;
      status_type status;
   } grant_type;

   localparam wide_type FRAME_LIMIT = wide_type'(1) << FRAME_BITS;

   wide_type    start_frame_reg = '0;
   wide_type    end_frame_reg   = wide_type'(END_FRAME_RESET);
   wide_type    frontier        = '0;
   frame_type   freed_frames [FREE_DEPTH];
   int unsigned freed_count     = 0;
   grant_type   granted_q [$];
   grant_type   want;

   int fails   = 0;
   int checked = 0;
   int n_oom   = 0;
   int n_dbl   = 0;
   int n_full  = 0;

   assign mismatch_count  = fails;
   assign pending_results = granted_q.size();
   assign checked_count   = checked;
   assign oom_count       = n_oom;
   assign double_count    = n_dbl;
   assign full_count      = n_full;

   // Frames are only handed out below the smaller of end_frame and 2^FRAME_BITS.
   function automatic wide_type usable_end();
      return (end_frame_reg < FRAME_LIMIT) ? end_frame_reg : FRAME_LIMIT;
   endfunction

   // Advance the allocator state by one request and return its response.
   function automatic grant_type grant_for_request(opcode_type op, frame_type frame,
                                                   wide_type len);
      grant_type             g;
      logic [FRAME_BITS+1:0] run_end;
      bit                    dup;
      int                    i;
      g.frame  = '0;
      g.status = ST_OK;
      dup      = 1'b0;
      run_end  = {1'b0, frontier} + {1'b0, len};
      case (op)
         OP_ALLOC: begin
            if (freed_count > 0) begin
               freed_count--;
               g.frame = freed_frames[freed_count];
            end else if (frontier < usable_end()) begin
               g.frame  = frontier[FRAME_BITS-1:0];
               frontier = frontier + 1'b1;
            end else begin
               g.status = ST_OOM;
            end
         end
         OP_RUN: begin
            if (run_end > {1'b0, usable_end()}) begin
               g.status = ST_OOM;
            end else begin
               if (frontier < FRAME_LIMIT) g.frame = frontier[FRAME_BITS-1:0];
               frontier = run_end[FRAME_BITS:0];
            end
         end
         OP_FREE: begin
            for (i = 0; i < freed_count; i++) begin
               if (freed_frames[i] == frame) dup = 1'b1;
            end
            if (dup) begin
               g.status = ST_DOUBLE;
            end else if (freed_count >= FREE_DEPTH) begin
               g.status = ST_FULL;
            end else begin
               freed_frames[freed_count] = frame;
               freed_count++;
            end
         end
         default: begin
            frontier    = start_frame_reg;
            freed_count = 0;
         end
      endcase
      return g;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start_frame_reg = '0;
         end_frame_reg   = wide_type'(END_FRAME_RESET);
         frontier        = '0;
         freed_count     = 0;
         granted_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_START_FRAME) start_frame_reg = csr_data;
            else if (csr_index == CSR_END_FRAME) end_frame_reg = csr_data;
         end
         // The response leaving now belongs to an earlier request.
         if (rsp_valid && rsp_ready) begin
            if (granted_q.size() == 0) begin
               $error("response with no request outstanding: frame_out %0h status %0d",
                      rsp_frame_out, rsp_status);
               fails++;
            end else begin
               want = granted_q.pop_front();
               if (rsp_frame_out !== want.frame) begin
                  $error("frame_out: expected %0h, actual %0h", want.frame, rsp_frame_out);
                  fails++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fails++;
               end
               checked++;
               case (want.status)
                  ST_OOM:    n_oom++;
                  ST_DOUBLE: n_dbl++;
                  ST_FULL:   n_full++;
                  default:   ;
               endcase
            end
         end
         if (req_valid && req_ready) begin
            granted_q.push_back(grant_for_request(req_opcode, req_frame_in, req_run_length));
         end
      end
   end

endmodule

>>> tb/sv/tb_page_frame_allocator.sv
`timescale 1ns / 100ps

module tb_page_frame_allocator;
   import pfa_pkg::*;

   localparam int FREE_DEPTH  = 1024;
   localparam int FRAME_BITS  = 20;
   // Even with a full free-stack scan per item plus the longest stalls, a run
   // of this size stays well below the limit.
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int CHUNK_ITEMS = 60;
   // Force an init once this many frees may sit on the stack, so scans stay short.
   localparam int FREE_BOUND  = 40;
   localparam int FIXED_SETTINGS = 7;

   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [FRAME_BITS:0]   wide_type;

   localparam wide_type WIDE_MAX    = '1;
   localparam wide_type FRAME_LIMIT = wide_type'(1) << FRAME_BITS;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   int       req_idle_pct     = 0;
   int       rsp_idle_pct     = 0;
   int       cycle_count      = 0;
   int       items_sent       = 0;
   int       frees_since_init = 0;
   int       settings_used    = 0;
   wide_type pool_base        = '0;

   // Register settings: reset values, a tight window, an end above 2^FRAME_BITS,
   // start above end, an empty range, a small window, a single frame below the top.
   wide_type fixed_start [FIXED_SETTINGS] = '{21'd0, 21'd100, 21'd1048552, 21'd2097151,
                                              21'd0, 21'd500, 21'd1048575};
   wide_type fixed_stop  [FIXED_SETTINGS] = '{21'd327680, 21'd140, 21'd2097151, 21'd0,
                                              21'd0, 21'd530, 21'd1048576};

   int mismatch_count;
   int pending_results;
   int checked_count;
   int oom_count;
   int double_count;
   int full_count;

   pfa_req_if #(.FRAME_BITS(FRAME_BITS)) req_bus ();
   pfa_rsp_if #(.FRAME_BITS(FRAME_BITS)) rsp_bus ();
   pfa_csr_if #(.FRAME_BITS(FRAME_BITS)) csr_bus ();

   page_frame_allocator #(
      .FREE_DEPTH(FREE_DEPTH),
      .FRAME_BITS(FRAME_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   pfa_alloc_checker #(
      .FREE_DEPTH(FREE_DEPTH),
      .FRAME_BITS(FRAME_BITS)
   ) alloc_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_opcode     (req_bus.opcode),
      .req_frame_in   (req_bus.frame_in),
      .req_run_length (req_bus.run_length),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_frame_out  (rsp_bus.frame_out),
      .rsp_status     (rsp_bus.status),
      .csr_valid      (csr_bus.valid),
      .csr_ready      (csr_bus.ready),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .mismatch_count (mismatch_count),
      .pending_results(pending_results),
      .checked_count  (checked_count),
      .oom_count      (oom_count),
      .double_count   (double_count),
      .full_count     (full_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 0;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_results);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver back-pressure: drop ready on a share of cycles set by the phase.
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   // Offer one request item and hold it until the block takes it.
   // Entered and left at a falling edge; valid stays high on return so that
   // back-to-back items need no low cycle between them.
   task automatic send_item(input opcode_type op, input frame_type frame,
                            input wide_type len);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.frame_in   <= frame;
      req_bus.run_length <= len;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (op == OP_INIT) frees_since_init = 0;
      else if (op == OP_FREE) frees_since_init++;
   endtask

   // Drop valid and wait until every response has come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input wide_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Reprogram both registers with the block idle.
   task automatic write_setting(input wide_type first_frame, input wide_type stop_frame);
      drain();
      write_reg(CSR_START_FRAME, first_frame);
      write_reg(CSR_END_FRAME, stop_frame);
      pool_base = first_frame;
      settings_used++;
   endtask

   // Walk the fixed settings first, then pick random windows.
   task automatic apply_setting(input int idx);
      wide_type first_frame;
      if (idx < FIXED_SETTINGS) begin
         write_setting(fixed_start[idx], fixed_stop[idx]);
      end else begin
         first_frame = wide_type'($urandom_range(FRAME_LIMIT - 1));
         write_setting(first_frame, first_frame + wide_type'($urandom_range(80)));
      end
   endtask

   // Mostly well-formed traffic: allocations, short runs and frees of frames
   // near the start of the window, so pops and double frees happen often.
   // Unused fields carry random bits so every input bit toggles.
   task automatic send_random_item();
      int         pick;
      opcode_type op;
      frame_type  frame;
      wide_type   len;
      pick  = $urandom_range(99);
      frame = frame_type'($urandom);
      len   = wide_type'($urandom);
      if (frees_since_init >= FREE_BOUND || pick < 6) begin
         op = OP_INIT;
      end else if (pick < 36) begin
         op = OP_ALLOC;
      end else if (pick < 54) begin
         op = OP_RUN;
         if ($urandom_range(9) < 7) len = wide_type'($urandom_range(6));
         else if ($urandom_range(1) == 1) len = wide_type'($urandom_range(64));
      end else begin
         op = OP_FREE;
         case ($urandom_range(3))
            0, 1:    frame = frame_type'(pool_base) + frame_type'($urandom_range(15));
            2:       frame = frame_type'($urandom_range(15));
            default: ;
         endcase
      end
      send_item(op, frame, len);
   endtask

   initial begin
      int phase;
      int chunk;
      int n;
      int setting_idx;

      req_bus.valid      = 1'b0;
      req_bus.opcode     = OP_ALLOC;
      req_bus.frame_in   = '0;
      req_bus.run_length = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_START_FRAME;
      csr_bus.data       = '0;
      setting_idx        = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Use before init: the frontier starts at frame 0.
      rsp_idle_pct = 50;
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_RUN, '0, '0);

      // Window 5..11: walk the frontier to the end and past it.
      write_setting(21'd5, 21'd12);
      send_item(OP_INIT, '1, '1);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_RUN, '0, 21'd3);
      send_item(OP_RUN, '0, '0);
      send_item(OP_RUN, '0, 21'd4);      // one past the end: out of memory
      send_item(OP_RUN, '0, 21'd3);      // exactly to the end
      send_item(OP_ALLOC, '0, '0);
      // Frame 0 is freed like any other; a second free of it is a double free.
      send_item(OP_FREE, '0, '0);
      send_item(OP_FREE, '0, '0);
      send_item(OP_FREE, '1, '0);
      send_item(OP_ALLOC, '0, '0);       // pops the most recent free first
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_RUN, '0, WIDE_MAX);
      send_item(OP_FREE, 20'd7, '0);
      send_item(OP_INIT, '0, '0);        // init empties the stack
      send_item(OP_ALLOC, '0, '0);

      // End above 2^FRAME_BITS: allocation stops at the frame limit.
      write_setting(FRAME_LIMIT - 2, WIDE_MAX);
      send_item(OP_INIT, '0, '0);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_RUN, '0, '0);         // zero run with frontier at the limit

      // Start above end: every frontier allocation fails.
      write_setting(WIDE_MAX, '0);
      send_item(OP_INIT, '0, '0);
      send_item(OP_ALLOC, '0, '0);
      send_item(OP_RUN, '0, '0);
      send_item(OP_FREE, '0, '0);
      send_item(OP_ALLOC, '0, '0);

      // Random part: fast sender and slow receiver, then the reverse, then
      // no idling at all; a new register setting every chunk.
      for (phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 83 : 0;
         rsp_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 30 : 0;
         for (chunk = 0; chunk < 3; chunk++) begin
            apply_setting(setting_idx);
            setting_idx++;
            send_item(OP_INIT, frame_type'($urandom), wide_type'($urandom));
            for (n = 0; n < CHUNK_ITEMS; n++) send_random_item();
         end
      end

      drain();
      repeat (20) @(negedge clock);

      $display("%0d request items sent, %0d responses checked",
               items_sent, checked_count);
      $display("%0d settings, three stall profiles: %0d out of memory, %0d double free",
               settings_used, oom_count, double_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
